@@ rtl/tcpc_pkg.sv @@
// tcpc_pkg: shared widths, reset values, register and symbol codes, and the
// queue entry that carries a division job from the front to the back.
// no dependencies; imported by every module of the pulse classifier.
package tcpc_pkg;

   localparam int CNT_W   = 8;
   localparam int MS_W    = 24;
   localparam int SEC_W   = 6;
   localparam int REG_W   = 12;
   localparam int Q4_W    = 26;
   localparam int PROD_W  = MS_W + CNT_W;
   localparam int NUM_W   = PROD_W + 2;
   localparam int DEN_W   = 2 * CNT_W;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [REG_W-1:0] MIN_PULSE_RST = 12'd100;
   localparam logic [REG_W-1:0] ZERO_MAX_RST  = 12'd350;
   localparam logic [REG_W-1:0] ONE_MAX_RST   = 12'd650;

   typedef enum logic [1:0] {
      REG_MIN_PULSE = 2'd0,
      REG_ZERO_MAX  = 2'd1,
      REG_ONE_MAX   = 2'd2
   } reg_idx_type;

   typedef enum logic [1:0] {
      SYM_NONE = 2'd0,
      SYM_ZERO = 2'd1,
      SYM_ONE  = 2'd2,
      SYM_MARK = 2'd3
   } symbol_type;

   typedef struct packed {
      logic [REG_W-1:0] min_pulse_ms;
      logic [REG_W-1:0] zero_max_ms;
      logic [REG_W-1:0] one_max_ms;
   } cfg_type;

   // estimate in quarter ms is num / den
   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic [SEC_W-1:0] sec;
   } div_job_type;

endpackage

@@ rtl/tcpc_front.sv @@
// tcpc_front: accepts one second of pulse evidence, works out the per-path
// spans and the products, and hands a num / den division job to the queue.
// depends on tcpc_pkg.
module tcpc_front import tcpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CNT_W-1:0]  req_time_count,
   input  logic [MS_W-1:0]   req_time_first,
   input  logic [MS_W-1:0]   req_time_last,
   input  logic [MS_W-1:0]   req_time_dur_total,
   input  logic [CNT_W-1:0]  req_freq_count,
   input  logic [MS_W-1:0]   req_freq_first,
   input  logic [MS_W-1:0]   req_freq_last,
   input  logic [MS_W-1:0]   req_freq_dur_total,
   input  logic [SEC_W-1:0]  req_second_of_minute,
   output logic              job_valid,
   input  logic              job_ready,
   output div_job_type       job
);

   typedef struct packed {
      logic              t_pos;
      logic              f_pos;
      logic              t_any;
      logic              f_any;
      logic [MS_W-1:0]   t_span;
      logic [MS_W-1:0]   f_span;
      logic [MS_W-1:0]   td;
      logic [MS_W-1:0]   fd;
      logic [CNT_W-1:0]  tc;
      logic [CNT_W-1:0]  fc;
      logic [PROD_W-1:0] p_tf;
      logic [PROD_W-1:0] p_ft;
      logic [DEN_W-1:0]  p_den;
      logic [SEC_W-1:0]  sec;
   } front_stage_type;

   front_stage_type stage_in, stage_ff;
   logic            stage_valid_in, stage_valid_ff;
   logic            stage_ready;
   logic [MS_W:0]   span_sum;
   logic [PROD_W:0] prod_sum;

   assign stage_ready = !stage_valid_ff || job_ready;
   assign req_ready   = stage_ready;

   always_comb begin
      stage_in.t_any = req_time_count != '0;
      stage_in.f_any = req_freq_count != '0;
      if (req_time_count >= CNT_W'(2)) begin
         stage_in.t_pos  = req_time_last > req_time_first;
         stage_in.t_span = req_time_last - req_time_first;
      end else begin
         stage_in.t_pos  = (req_time_count == CNT_W'(1)) && (req_time_dur_total != '0);
         stage_in.t_span = req_time_dur_total;
      end
      if (req_freq_count >= CNT_W'(2)) begin
         stage_in.f_pos  = req_freq_last > req_freq_first;
         stage_in.f_span = req_freq_last - req_freq_first;
      end else begin
         stage_in.f_pos  = (req_freq_count == CNT_W'(1)) && (req_freq_dur_total != '0);
         stage_in.f_span = req_freq_dur_total;
      end
      stage_in.td    = req_time_dur_total;
      stage_in.fd    = req_freq_dur_total;
      stage_in.tc    = req_time_count;
      stage_in.fc    = req_freq_count;
      stage_in.p_tf  = PROD_W'(req_time_dur_total) * PROD_W'(req_freq_count);
      stage_in.p_ft  = PROD_W'(req_freq_dur_total) * PROD_W'(req_time_count);
      stage_in.p_den = DEN_W'(req_time_count) * DEN_W'(req_freq_count);
      stage_in.sec   = req_second_of_minute;
   end

   assign stage_valid_in = stage_ready ? req_valid : stage_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && stage_ready) begin
         stage_ff <= stage_in;
      end
   end

   assign span_sum = {1'b0, stage_ff.t_span} + {1'b0, stage_ff.f_span};
   assign prod_sum = {1'b0, stage_ff.p_tf} + {1'b0, stage_ff.p_ft};

   // spans win over mean durations; den is one unless mean durations are used
   always_comb begin
      job.sec = stage_ff.sec;
      job.den = DEN_W'(1);
      if (stage_ff.t_pos && stage_ff.f_pos) begin
         job.num = NUM_W'({span_sum, 1'b0});
      end else if (stage_ff.t_pos) begin
         job.num = NUM_W'({stage_ff.t_span, 2'b00});
      end else if (stage_ff.f_pos) begin
         job.num = NUM_W'({stage_ff.f_span, 2'b00});
      end else if (stage_ff.t_any && stage_ff.f_any) begin
         job.num = NUM_W'({prod_sum, 1'b0});
         job.den = stage_ff.p_den;
      end else if (stage_ff.t_any) begin
         job.num = NUM_W'({stage_ff.td, 2'b00});
         job.den = DEN_W'(stage_ff.tc);
      end else if (stage_ff.f_any) begin
         job.num = NUM_W'({stage_ff.fd, 2'b00});
         job.den = DEN_W'(stage_ff.fc);
      end else begin
         job.num = '0;
      end
   end

   assign job_valid = stage_valid_ff;

endmodule

@@ rtl/tcpc_fifo.sv @@
// tcpc_fifo: short queue of division jobs between the front and the back,
// so each side can stall on its own.
// depends on tcpc_pkg.
module tcpc_fifo import tcpc_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  div_job_type push_data,
   output logic        pop_valid,
   input  logic        pop_ready,
   output div_job_type pop_data
);

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   div_job_type       slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_in, wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in, rd_ptr_ff;
   logic [FILL_W-1:0] fill_in, fill_ff;
   logic              push, pop;

   assign push_ready = fill_ff != FILL_W'(DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/tcpc_back.sv @@
// tcpc_back: pipelined restoring divider, one quotient bit per stage, then
// threshold classification into the result register.
// depends on tcpc_pkg.
module tcpc_back import tcpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  div_job_type       job,
   input  cfg_type           cfg,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [Q4_W-1:0]   rsp_pulse_len_q4,
   output logic [1:0]        rsp_symbol
);

   localparam int STEPS = Q4_W;

   // lq holds the dividend bits still to come on top, quotient bits below
   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [Q4_W-1:0]  lq;
      logic [DEN_W-1:0] den;
      logic [SEC_W-1:0] sec;
   } div_stage_type;

   div_stage_type    st_in [STEPS];
   div_stage_type    st_ff [STEPS];
   div_stage_type    start;
   div_stage_type    last_st;
   logic [STEPS-1:0] st_valid_in, st_valid_ff;
   logic             advance;
   logic             frac;
   symbol_type       sym;
   logic             rsp_valid_in, rsp_valid_ff;
   logic [Q4_W-1:0]  rsp_len_ff;
   symbol_type       rsp_sym_ff;

   function automatic div_stage_type div_step(div_stage_type s);
      logic [DEN_W:0] trial;
      div_stage_type  r;
      trial = {s.rem, s.lq[Q4_W-1]};
      r     = s;
      if (trial >= {1'b0, s.den}) begin
         r.rem = DEN_W'(trial - {1'b0, s.den});
         r.lq  = {s.lq[Q4_W-2:0], 1'b1};
      end else begin
         r.rem = trial[DEN_W-1:0];
         r.lq  = {s.lq[Q4_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // exact estimate q4 + frac not above lim ms
   function automatic logic not_above(logic [Q4_W-1:0] q, logic f, logic [REG_W-1:0] lim);
      logic [Q4_W-1:0] l4;
      l4 = Q4_W'({lim, 2'b00});
      return (q < l4) || ((q == l4) && !f);
   endfunction

   function automatic logic is_marker_second(logic [SEC_W-1:0] s);
      logic hit;
      case (s) inside
         6'd0, 6'd9, 6'd19, 6'd29, 6'd39, 6'd49, 6'd59: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // the whole pipe moves together; it only holds while a result waits
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign job_ready = advance;

   // quotient is always below 2^Q4_W, so the top dividend bits are below den
   always_comb begin
      start.rem = DEN_W'(job.num[NUM_W-1:Q4_W]);
      start.lq  = job.num[Q4_W-1:0];
      start.den = job.den;
      start.sec = job.sec;
   end

   always_comb begin
      st_in[0] = div_step(start);
      for (int k = 1; k < STEPS; k++) begin
         st_in[k] = div_step(st_ff[k-1]);
      end
   end

   assign st_valid_in = advance ? {st_valid_ff[STEPS-2:0], job_valid} : st_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= '0;
      end else begin
         st_valid_ff <= st_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < STEPS; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign last_st = st_ff[STEPS-1];
   assign frac    = last_st.rem != '0;

   always_comb begin
      if (last_st.lq < Q4_W'({cfg.min_pulse_ms, 2'b00})) begin
         sym = SYM_NONE;
      end else if (not_above(last_st.lq, frac, cfg.zero_max_ms)) begin
         sym = SYM_ZERO;
      end else if (not_above(last_st.lq, frac, cfg.one_max_ms)) begin
         sym = SYM_ONE;
      end else if (is_marker_second(last_st.sec)) begin
         sym = SYM_MARK;
      end else begin
         sym = SYM_ONE;
      end
   end

   assign rsp_valid_in = advance ? st_valid_ff[STEPS-1] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input widths keep the quotient inside Q4_W bits, so no clamp is needed
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_len_ff <= last_st.lq;
         rsp_sym_ff <= sym;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pulse_len_q4 = rsp_len_ff;
   assign rsp_symbol       = rsp_sym_ff;

endmodule

@@ rtl/time_code_pulse_classifier.sv @@
// time_code_pulse_classifier: top level with the threshold registers and
// the register port, joining the front, the job queue and the divider back.
// depends on tcpc_pkg, tcpc_front, tcpc_fifo and tcpc_back.

// Takes one item per clock and keeps that rate as long as results are taken;
// a result passes, in order, one front stage, a slot of the job queue,
// 26 divider stages (one quotient bit each) and the result register.
// The 26-stage restoring divider is the longest part of that path.
// Pulse length comes out in quarter milliseconds, truncated; the symbol is
// 0 none, 1 zero, 2 one, 3 position marker, and thresholds compare against
// the exact untruncated estimate. Thresholds sit at byte addresses 0, 4 and
// 8 (minimum pulse, zero maximum, one maximum, 12 bits each, in ms) and are
// to be written only while no item is in flight.
module time_code_pulse_classifier import tcpc_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CNT_W-1:0]   req_time_count,
   input  logic [MS_W-1:0]    req_time_first,
   input  logic [MS_W-1:0]    req_time_last,
   input  logic [MS_W-1:0]    req_time_dur_total,
   input  logic [CNT_W-1:0]   req_freq_count,
   input  logic [MS_W-1:0]    req_freq_first,
   input  logic [MS_W-1:0]    req_freq_last,
   input  logic [MS_W-1:0]    req_freq_dur_total,
   input  logic [SEC_W-1:0]   req_second_of_minute,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [Q4_W-1:0]    rsp_pulse_len_q4,
   output logic [1:0]         rsp_symbol,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready
);

   cfg_type     cfg_in, cfg_ff;
   logic        cfg_wr;
   logic        q_push_valid, q_push_ready;
   logic        q_pop_valid, q_pop_ready;
   div_job_type q_tail, q_head;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         case (paddr[3:2])
            REG_MIN_PULSE: cfg_in.min_pulse_ms = pwdata[REG_W-1:0];
            REG_ZERO_MAX:  cfg_in.zero_max_ms  = pwdata[REG_W-1:0];
            REG_ONE_MAX:   cfg_in.one_max_ms   = pwdata[REG_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_pulse_ms <= MIN_PULSE_RST;
         cfg_ff.zero_max_ms  <= ZERO_MAX_RST;
         cfg_ff.one_max_ms   <= ONE_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_MIN_PULSE: prdata = DATA_W'(cfg_ff.min_pulse_ms);
         REG_ZERO_MAX:  prdata = DATA_W'(cfg_ff.zero_max_ms);
         REG_ONE_MAX:   prdata = DATA_W'(cfg_ff.one_max_ms);
         default:       prdata = '0;
      endcase
   end

   tcpc_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_time_count       (req_time_count),
      .req_time_first       (req_time_first),
      .req_time_last        (req_time_last),
      .req_time_dur_total   (req_time_dur_total),
      .req_freq_count       (req_freq_count),
      .req_freq_first       (req_freq_first),
      .req_freq_last        (req_freq_last),
      .req_freq_dur_total   (req_freq_dur_total),
      .req_second_of_minute (req_second_of_minute),
      .job_valid            (q_push_valid),
      .job_ready            (q_push_ready),
      .job                  (q_tail)
   );

   tcpc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_tail),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_head)
   );

   tcpc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (q_pop_valid),
      .job_ready        (q_pop_ready),
      .job              (q_head),
      .cfg              (cfg_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pulse_len_q4 (rsp_pulse_len_q4),
      .rsp_symbol       (rsp_symbol)
   );

   // a job leaving the queue never divides by zero
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (q_pop_valid && q_pop_ready) |-> (q_head.den != '0))
      else $error("division job with zero divisor");

   a_mark_long: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_symbol == SYM_MARK) |->
      (rsp_pulse_len_q4 >= Q4_W'({cfg_ff.one_max_ms, 2'b00})))
      else $error("marker given for a pulse within the one range");

   a_none_short: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_symbol == SYM_NONE) |->
      (rsp_pulse_len_q4 < Q4_W'({cfg_ff.min_pulse_ms, 2'b00})))
      else $error("no symbol given for a pulse at or above the minimum");

   a_cfg_write: assert property (@(posedge clock) disable iff (reset)
      (cfg_wr && paddr[3:2] == REG_MIN_PULSE) |=>
      (cfg_ff.min_pulse_ms == $past(pwdata[REG_W-1:0])))
      else $error("minimum pulse register not updated by write");

endmodule
